// File: hw/rtl/rpb_pkg.sv
// ----------------------------------------------------------------------------
// rpb_pkg
// shared types and constants for the rgba pixel blender
// ----------------------------------------------------------------------------
package rpb_pkg;

    localparam logic [7:0] CHAN_MAX = 8'd255;
    localparam int NUM_W = 26;
    localparam int DEN_W = 16;
    // front end two stages, divider nine, result register one
    localparam int LATENCY = 12;

    typedef enum logic [2:0] {
        MODE_ALPHA    = 3'd0,
        MODE_MULT     = 3'd1,
        MODE_SRC_OVER = 3'd2,
        MODE_DJ_OVER  = 3'd3,
        MODE_DJ_UNDER = 3'd4,
        MODE_DJ_DEBUG = 3'd5
    } t_mode;

    // one division job: quotient saturates at 255, override replaces it
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             ovr;
        logic [7:0]       ovv;
    } t_lane;

endpackage

// File: hw/rtl/rpb_front.sv
// ----------------------------------------------------------------------------
// rpb_front
// two stage front end: products, then numerators and denominators per lane
// ----------------------------------------------------------------------------
module rpb_front (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2:0]             i_mode,
    input  logic [2:0][7:0]        i_cb,
    input  logic [2:0][7:0]        i_ct,
    input  logic [7:0]             i_ab,
    input  logic [7:0]             i_at,
    output rpb_pkg::t_lane [3:0]   o_lane
);

    rpb_pkg::t_mode              n_mode, r_mode;
    logic [2:0][15:0]            n_x, r_x, n_y, r_y;
    logic [2:0][7:0]             r_cb, r_ct;
    logic [7:0]                  r_ab, r_at;
    logic [15:0]                 n_d0, r_d0, n_d2, r_d2;
    logic [7:0]                  fx, fy;
    rpb_pkg::t_lane [3:0]        n_lane, r_lane;
    logic                        low, both, both_in;
    logic [8:0]                  sum_a;
    logic [23:0]                 yk;

    always_comb begin
        n_mode  = (i_mode > 3'(rpb_pkg::MODE_DJ_DEBUG)) ? rpb_pkg::MODE_ALPHA
                                                        : rpb_pkg::t_mode'(i_mode);
        both_in = (i_ab != 8'd0) && (i_at != 8'd0);
        fx      = i_ab;
        fy      = i_at;
        case (n_mode)
            rpb_pkg::MODE_MULT: begin
                fx = rpb_pkg::CHAN_MAX - i_at;
                fy = i_at;
            end
            rpb_pkg::MODE_DJ_OVER: begin
                fx = rpb_pkg::CHAN_MAX - i_at;
                fy = i_ab;
            end
            rpb_pkg::MODE_DJ_UNDER: begin
                fx = both_in ? i_at : rpb_pkg::CHAN_MAX;
                fy = rpb_pkg::CHAN_MAX - i_ab;
            end
            default: begin
                fx = i_ab;
                fy = i_at;
            end
        endcase
        for (int c = 0; c < 3; c++) begin
            n_x[c] = 16'(i_cb[c]) * 16'(fx);
            n_y[c] = 16'(i_ct[c]) * 16'(fy);
        end
        n_d0 = 16'({i_at, 8'd0} - {8'd0, i_at})
             + 16'(i_ab) * 16'(rpb_pkg::CHAN_MAX - i_at);
        n_d2 = 16'({i_ab, 8'd0} - {8'd0, i_ab})
             + 16'(i_at) * 16'(rpb_pkg::CHAN_MAX - i_ab);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode <= n_mode;
            r_x    <= n_x;
            r_y    <= n_y;
            r_cb   <= i_cb;
            r_ct   <= i_ct;
            r_ab   <= i_ab;
            r_at   <= i_at;
            r_d0   <= n_d0;
            r_d2   <= n_d2;
        end
    end

    always_comb begin
        sum_a  = 9'(r_ab) + 9'(r_at);
        low    = sum_a < 9'(rpb_pkg::CHAN_MAX);
        both   = (r_ab != 8'd0) && (r_at != 8'd0);
        n_lane = '0;
        for (int c = 0; c < 3; c++) begin
            yk = 24'(r_y[c]) * 24'(rpb_pkg::CHAN_MAX - r_ab);
            n_lane[c].num = rpb_pkg::NUM_W'(r_x[c]) + rpb_pkg::NUM_W'(r_y[c]);
            n_lane[c].den = 16'(rpb_pkg::CHAN_MAX);
            n_lane[c].ovr = 1'b0;
            n_lane[c].ovv = 8'd0;
            case (r_mode)
                rpb_pkg::MODE_ALPHA, rpb_pkg::MODE_SRC_OVER: begin
                    n_lane[c].num = rpb_pkg::NUM_W'({r_x[c], 8'd0})
                                  - rpb_pkg::NUM_W'(r_x[c]) + rpb_pkg::NUM_W'(yk);
                    n_lane[c].den = (r_mode == rpb_pkg::MODE_ALPHA) ? r_d0 : r_d2;
                    n_lane[c].ovr = (n_lane[c].den == 16'd0);
                end
                rpb_pkg::MODE_DJ_OVER: begin
                    if (!low) begin
                        n_lane[c].num = rpb_pkg::NUM_W'(r_cb[c]) + rpb_pkg::NUM_W'(r_ct[c]);
                        n_lane[c].den = 16'd1;
                    end else if (r_ab == 8'd0) begin
                        // clear base: any nonzero base colour saturates, a zero one passes the top colour
                        n_lane[c].ovr = 1'b1;
                        n_lane[c].ovv = (r_cb[c] != 8'd0) ? rpb_pkg::CHAN_MAX : r_ct[c];
                    end else begin
                        n_lane[c].den = 16'(r_ab);
                    end
                end
                rpb_pkg::MODE_DJ_UNDER: begin
                    n_lane[c].den = both ? 16'(r_at) : 16'(rpb_pkg::CHAN_MAX);
                end
                rpb_pkg::MODE_DJ_DEBUG: begin
                    n_lane[c].ovr = 1'b1;
                    if (c == 0)      n_lane[c].ovv = low ? 8'd0 : rpb_pkg::CHAN_MAX;
                    else if (c == 1) n_lane[c].ovv = low ? rpb_pkg::CHAN_MAX : 8'd0;
                    else             n_lane[c].ovv = 8'd0;
                end
                default: begin
                    n_lane[c].den = 16'(rpb_pkg::CHAN_MAX);
                end
            endcase
        end
        // alpha lane
        n_lane[3].ovr = 1'b0;
        n_lane[3].ovv = 8'd0;
        if (r_mode == rpb_pkg::MODE_ALPHA || r_mode == rpb_pkg::MODE_SRC_OVER) begin
            n_lane[3].num = rpb_pkg::NUM_W'(r_d2);
            n_lane[3].den = 16'(rpb_pkg::CHAN_MAX);
        end else begin
            n_lane[3].num = rpb_pkg::NUM_W'(sum_a);
            n_lane[3].den = 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// File: hw/rtl/rpb_div.sv
// ----------------------------------------------------------------------------
// rpb_div
// pipelined restoring divider, one quotient bit per stage, saturating at 255
// ----------------------------------------------------------------------------
module rpb_div (
    input  logic            i_clk,
    input  logic            i_en,
    input  rpb_pkg::t_lane  i_lane,
    output logic [7:0]      o_q
);

    localparam int STEPS = 8;

    logic [rpb_pkg::NUM_W-1:0] r_rem [0:STEPS];
    logic [rpb_pkg::DEN_W-1:0] r_den [0:STEPS];
    logic [7:0]                r_q   [0:STEPS];
    logic                      r_sat [0:STEPS];
    logic                      r_ovr [0:STEPS];
    logic [7:0]                r_ovv [0:STEPS];
    logic [7:0]                r_res;

    // first stage only decides whether the quotient reaches 256
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_lane.num;
            r_den[0] <= i_lane.den;
            r_q[0]   <= 8'd0;
            r_sat[0] <= i_lane.num >= {2'b00, i_lane.den, 8'd0};
            r_ovr[0] <= i_lane.ovr;
            r_ovv[0] <= i_lane.ovv;
        end
    end

    for (genvar j = 1; j <= STEPS; j++) begin : g_step
        localparam int K = STEPS - j;
        logic [rpb_pkg::NUM_W-1:0] dsh;
        logic                      take;
        assign dsh  = rpb_pkg::NUM_W'(r_den[j-1]) << K;
        assign take = r_rem[j-1] >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? r_rem[j-1] - dsh : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (take ? (8'd1 << K) : 8'd0);
                r_den[j] <= r_den[j-1];
                r_sat[j] <= r_sat[j-1];
                r_ovr[j] <= r_ovr[j-1];
                r_ovv[j] <= r_ovv[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_ovr[STEPS] ? r_ovv[STEPS]
                   : (r_sat[STEPS] ? rpb_pkg::CHAN_MAX : r_q[STEPS]);
        end
    end

    assign o_q = r_res;

endmodule

// File: hw/rtl/rgba_pixel_blender_top.sv
// throughput: one pixel per cycle unless the output stalls, set by the one-bit-per-stage divider
// a stall at the output while o_valid is high freezes the whole pipeline, nothing lost or repeated
// reset (synchronous, active low) clears valid bits and sets the mode to alpha
// ----------------------------------------------------------------------------
// rgba_pixel_blender_top
// rgba8 compositing pipeline with six selectable blend modes
// ----------------------------------------------------------------------------
module rgba_pixel_blender_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_base_red,
    input  logic [7:0] i_base_green,
    input  logic [7:0] i_base_blue,
    input  logic [7:0] i_base_alpha,
    input  logic [7:0] i_top_red,
    input  logic [7:0] i_top_green,
    input  logic [7:0] i_top_blue,
    input  logic [7:0] i_top_alpha,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha
);

    logic [2:0]                  r_mode;
    logic [rpb_pkg::LATENCY-1:0] r_vld;
    logic                        en;
    rpb_pkg::t_lane [3:0]        lane;
    logic [3:0][7:0]             q;

    assign en      = !(r_vld[rpb_pkg::LATENCY-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 3'(rpb_pkg::MODE_ALPHA);
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (en) begin
                r_vld <= {r_vld[rpb_pkg::LATENCY-2:0], i_valid};
            end
        end
    end

    rpb_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mode (r_mode),
        .i_cb   ({i_base_blue, i_base_green, i_base_red}),
        .i_ct   ({i_top_blue, i_top_green, i_top_red}),
        .i_ab   (i_base_alpha),
        .i_at   (i_top_alpha),
        .o_lane (lane)
    );

    for (genvar l = 0; l < 4; l++) begin : g_lane
        rpb_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (lane[l]),
            .o_q    (q[l])
        );
    end

    assign o_valid     = r_vld[rpb_pkg::LATENCY-1];
    assign o_out_red   = q[0];
    assign o_out_green = q[1];
    assign o_out_blue  = q[2];
    assign o_out_alpha = q[3];

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid set after reset");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted transaction not tracked");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule
